@@ hw/rtl/acpu_pkg.sv @@
// shared types and constants of the accumulator cpu step unit
`timescale 1ns / 1ps

package acpu_pkg;

    localparam int PROG_WORDS = 256;
    localparam int PROG_AW    = $clog2(PROG_WORDS);
    localparam int RAM_WORDS  = 256;
    localparam int RAM_AW     = $clog2(RAM_WORDS);
    localparam int NUM_REGS   = 8;
    localparam int REG_AW     = $clog2(NUM_REGS);

    // clearing pass after reset covers the larger of the two memories
    localparam int CLR_WORDS  = (PROG_WORDS > RAM_WORDS) ? PROG_WORDS : RAM_WORDS;
    localparam int CLR_AW     = $clog2(CLR_WORDS);

    // item kinds carried on the input tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EXEC = 1'b1;

    // opcodes
    localparam logic [7:0] OP_ADD  = 8'h01;
    localparam logic [7:0] OP_NOT  = 8'h02;
    localparam logic [7:0] OP_SAVE = 8'h04;
    localparam logic [7:0] OP_MOVE = 8'h08;
    localparam logic [7:0] OP_IMM  = 8'h10;
    localparam logic [7:0] OP_JUMP = 8'h20;
    localparam logic [7:0] OP_LOAD = 8'h40;
    localparam logic [7:0] OP_STOR = 8'h80;

    // sticky halt codes
    typedef enum logic [1:0] {
        HALT_RUN     = 2'd0,
        HALT_BAD_SEL = 2'd1,
        HALT_BAD_OP  = 2'd2
    } halt_t;

endpackage

@@ hw/rtl/accumulator_cpu_8bit_step_unit.sv @@
// top level of the accumulator cpu step unit: memories, fetch and execute stages
`timescale 1ns / 1ps

// Tiny 8-bit accumulator cpu driven one transaction at a time. A transaction with
// s_tuser = 0 writes load_byte into the 256-byte program store at load_addr; one with
// s_tuser = 1 runs the instruction (opcode at pc, operand at pc+1). Every transaction
// returns exactly one result holding pc, acc and the sticky halt status after it. The
// unit accepts one transaction per cycle while m_tready is high and presents its result
// on m_tdata: the accepting edge reads the program store (two read ports) and the data
// ram at acc into the fetch stage; when it advances, the unit decodes, executes, writes
// back and loads the result register. The fetch addresses of a new instruction are
// taken from the execute stage's next pc and acc, and a data ram store is forwarded
// into a read of the same address in that cycle, so back-to-back instructions need no
// bubble. A stalled result holds s_tready low once the fetch stage is full. After reset
// a clearing pass zeroes both memories one word per cycle, holding s_tready low.
module accumulator_cpu_8bit_step_unit
    import acpu_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] load_addr, [15:8] load_byte
    input  logic [0:0]  s_tuser,   // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] pc_now, [15:8] acc_now, [17:16] status, rest 0
);

    // architectural state
    logic [7:0] pc_reg, acc_reg;
    halt_t      halt_reg;
    logic [7:0] rf_reg [NUM_REGS];

    // memories and their clearing pass
    logic [7:0] prog_mem [PROG_WORDS];
    logic [7:0] ram_mem  [RAM_WORDS];
    logic              clr_busy_reg;
    logic [CLR_AW-1:0] clr_addr_reg;

    // fetch stage registers
    logic       s1_valid_reg, s1_exec_reg;
    logic [7:0] op_rd_reg, arg_rd_reg, ram_rd_reg;

    // output register
    logic        out_valid_reg;
    logic [23:0] out_data_reg;

    // handshake
    logic in_fire, advance;
    logic [PROG_AW-1:0] ld_addr;
    logic [7:0]         ld_byte;

    // execute stage
    logic              exec_ok, sel_onehot;
    logic [REG_AW-1:0] sel_idx;
    logic [7:0]        rf_rd;
    logic [7:0]        pc_next, acc_next;
    halt_t             halt_next;
    logic              rf_we, ram_we;

    // fetch addresses, forwarded from the execute stage when it commits
    logic [PROG_AW-1:0] op_addr, arg_addr;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [7:0]         pc_fwd, acc_fwd;

    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!s1_valid_reg || advance);
    assign in_fire  = s_tvalid && s_tready;
    assign ld_addr  = s_tdata[PROG_AW-1:0];
    assign ld_byte  = s_tdata[15:8];

    // ---------------------------------------------------------------- execute
    always_comb begin
        sel_idx = '0;
        for (int k = 0; k < NUM_REGS; k++) begin
            if (arg_rd_reg[k]) begin
                sel_idx = REG_AW'(k);
            end
        end
    end

    // exactly one bit set
    assign sel_onehot = (arg_rd_reg != 8'd0) && ((arg_rd_reg & (arg_rd_reg - 8'd1)) == 8'd0);
    assign rf_rd      = rf_reg[sel_idx];
    assign exec_ok    = s1_exec_reg && (halt_reg == HALT_RUN);

    always_comb begin
        pc_next   = pc_reg;
        acc_next  = acc_reg;
        halt_next = halt_reg;
        rf_we     = 1'b0;
        ram_we    = 1'b0;
        if (exec_ok) begin
            if (op_rd_reg != OP_IMM && !sel_onehot) begin
                // bad register select wins over the opcode check, pc stays put
                halt_next = HALT_BAD_SEL;
            end else begin
                pc_next = pc_reg + 8'd2;
                case (op_rd_reg)
                    OP_ADD:  acc_next = acc_reg + rf_rd;
                    OP_NOT:  acc_next = ~rf_rd;
                    OP_SAVE: rf_we = 1'b1;
                    OP_MOVE: acc_next = rf_rd;
                    OP_IMM:  acc_next = arg_rd_reg;
                    OP_JUMP: begin
                        if (acc_reg[7]) begin
                            pc_next = rf_rd;
                        end
                    end
                    OP_LOAD: rf_we = 1'b1;
                    OP_STOR: ram_we = 1'b1;
                    default: begin
                        pc_next   = pc_reg;
                        halt_next = HALT_BAD_OP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            halt_reg <= HALT_RUN;
            for (int i = 0; i < NUM_REGS; i++) begin
                rf_reg[i] <= '0;
            end
        end else if (advance) begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            halt_reg <= halt_next;
            if (rf_we) begin
                // save takes acc, load takes the data ram word at acc
                rf_reg[sel_idx] <= (op_rd_reg == OP_SAVE) ? acc_reg : ram_rd_reg;
            end
        end
    end

    // ---------------------------------------------------------------- fetch
    assign pc_fwd    = advance ? pc_next  : pc_reg;
    assign acc_fwd   = advance ? acc_next : acc_reg;
    assign op_addr   = pc_fwd[PROG_AW-1:0];
    assign arg_addr  = PROG_AW'(pc_fwd + 8'd1);   // operand address wraps
    assign ram_raddr = acc_fwd[RAM_AW-1:0];

    // one word of each memory zeroed per cycle after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + CLR_AW'(1);
            if (clr_addr_reg == CLR_AW'(CLR_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // program store: written by load transactions at acceptance, two read ports
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            prog_mem[PROG_AW'(clr_addr_reg)] <= 8'd0;
        end else if (in_fire && s_tuser[0] == FUNC_LOAD) begin
            prog_mem[ld_addr] <= ld_byte;
        end
        if (in_fire && s_tuser[0] == FUNC_EXEC) begin
            op_rd_reg  <= prog_mem[op_addr];
            arg_rd_reg <= prog_mem[arg_addr];
        end
    end

    // data ram: written by a committing store, read at the forwarded acc
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            ram_mem[RAM_AW'(clr_addr_reg)] <= 8'd0;
        end else if (advance && ram_we) begin
            ram_mem[acc_reg[RAM_AW-1:0]] <= rf_rd;
        end
        if (in_fire && s_tuser[0] == FUNC_EXEC) begin
            if (advance && ram_we && acc_reg[RAM_AW-1:0] == ram_raddr) begin
                ram_rd_reg <= rf_rd;   // store to the same word in this cycle
            end else begin
                ram_rd_reg <= ram_mem[ram_raddr];
            end
        end
    end

    // fetch stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_exec_reg  <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
            s1_exec_reg  <= s_tvalid && (s_tuser[0] == FUNC_EXEC);
        end
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'd0, halt_next, acc_next, pc_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench of the accumulator cpu step unit
`timescale 1ns / 1ps

module testbench
    import acpu_pkg::*;
();

    // pc, acc and halt status as reported by one result transaction
    typedef struct packed {
        logic [7:0] pc;
        logic [7:0] acc;
        halt_t      status;
    } cpu_view_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] load_addr, [15:8] load_byte
    logic [0:0]  s_tuser;   // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] pc_now, [15:8] acc_now, [17:16] status, rest 0

    // shadow copy of the cpu state, advanced once per accepted input transaction
    logic [7:0] shadow_pc;
    logic [7:0] shadow_acc;
    logic [7:0] shadow_regs [NUM_REGS];
    logic [7:0] shadow_ram  [RAM_WORDS];
    logic [7:0] shadow_prog [PROG_WORDS];
    halt_t      shadow_halt;

    // cpu views still owed by the unit, oldest first
    cpu_view_t expected_views [$];

    bit idle_on;
    int items_sent;
    int exec_count;
    int jumps_taken;
    int results_checked;
    int mismatch_count;

    accumulator_cpu_8bit_step_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("timeout with %0d results still owed", expected_views.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // register index of a one-hot select, -1 when the byte is not one-hot
    function automatic int select_index(input logic [7:0] sel);
        for (int k = 0; k < NUM_REGS; k++) begin
            if (sel == (8'd1 << k)) return k;
        end
        return -1;
    endfunction

    // true when the instruction at addr would run without halting;
    // the eight opcodes are exactly the one-hot bytes
    function automatic bit instruction_runs(input logic [7:0] addr);
        logic [7:0] op;
        logic [7:0] arg_addr;
        op = shadow_prog[addr];
        arg_addr = addr + 8'd1;
        if (op == OP_IMM) return 1'b1;
        return select_index(shadow_prog[arg_addr]) >= 0 && select_index(op) >= 0;
    endfunction

    function automatic logic [7:0] pick_opcode();
        case ($urandom_range(0, 7))
            0: return OP_ADD;
            1: return OP_NOT;
            2: return OP_SAVE;
            3: return OP_MOVE;
            4: return OP_IMM;
            5: return OP_JUMP;
            6: return OP_LOAD;
            default: return OP_STOR;
        endcase
    endfunction

    // any byte that is neither a register select nor an opcode, zero often
    function automatic logic [7:0] non_onehot_byte();
        logic [7:0] v;
        if ($urandom_range(0, 3) == 0) return 8'h00;
        do v = 8'($urandom_range(0, 255)); while (select_index(v) >= 0);
        return v;
    endfunction

    // applies one input transaction to the shadow state, returns the view it should report
    function automatic cpu_view_t advance_cpu_model(input logic func, input logic [7:0] addr,
                                                    input logic [7:0] data);
        cpu_view_t  view;
        logic [7:0] op;
        logic [7:0] arg;
        logic [7:0] arg_addr;
        logic [7:0] next_pc;
        logic [2:0] ridx;
        int         sel;
        bit         known;
        if (func == FUNC_LOAD) begin
            // loads always land, halted or not
            shadow_prog[addr] = data;
        end else if (shadow_halt == HALT_RUN) begin
            exec_count++;
            arg_addr = shadow_pc + 8'd1;   // operand of pc 255 comes from address 0
            op = shadow_prog[shadow_pc];
            arg = shadow_prog[arg_addr];
            next_pc = shadow_pc + 8'd2;
            sel = select_index(arg);
            if (op != OP_IMM && sel < 0) begin
                // select check wins over the opcode check, pc stays on the fault
                shadow_halt = HALT_BAD_SEL;
            end else begin
                ridx = sel[2:0];
                known = 1'b1;
                case (op)
                    OP_ADD:  shadow_acc = shadow_acc + shadow_regs[ridx];
                    OP_NOT:  shadow_acc = ~shadow_regs[ridx];
                    OP_SAVE: shadow_regs[ridx] = shadow_acc;
                    OP_MOVE: shadow_acc = shadow_regs[ridx];
                    OP_IMM:  shadow_acc = arg;
                    OP_JUMP: begin
                        if (shadow_acc[7]) begin
                            next_pc = shadow_regs[ridx];
                            jumps_taken++;
                        end
                    end
                    OP_LOAD: shadow_regs[ridx] = shadow_ram[shadow_acc];
                    OP_STOR: shadow_ram[shadow_acc] = shadow_regs[ridx];
                    default: known = 1'b0;
                endcase
                if (known) shadow_pc = next_pc;
                else shadow_halt = HALT_BAD_OP;
            end
        end
        view.pc = shadow_pc;
        view.acc = shadow_acc;
        view.status = shadow_halt;
        return view;
    endfunction

    // drive one input transaction, optionally after an idle burst, and record its outcome
    task automatic issue_item(input logic func, input logic [7:0] addr, input logic [7:0] data);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= func;
        s_tdata <= {data, addr};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        expected_views.push_back(advance_cpu_model(func, addr, data));
    endtask

    // address and data fields are don't-care on an execute, so they carry noise
    task automatic issue_exec();
        issue_item(FUNC_EXEC, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // write opcode and operand at the current pc
    task automatic place_instruction(input logic [7:0] op, input logic [7:0] arg);
        logic [7:0] arg_addr;
        arg_addr = shadow_pc + 8'd1;
        issue_item(FUNC_LOAD, shadow_pc, op);
        issue_item(FUNC_LOAD, arg_addr, arg);
    endtask

    // every opcode once, an immediate with a non-one-hot operand, a taken jump to
    // the top of the store, operand fetch wrapping to address 0 and pc wrapping
    task automatic test_directed_program();
        logic [7:0] ops  [8];
        logic [7:0] args [8];
        ops  = '{OP_IMM, OP_SAVE, OP_ADD, OP_NOT, OP_STOR, OP_LOAD, OP_MOVE, OP_JUMP};
        args = '{8'hFF,  8'h80,   8'h80,  8'h01,  8'h80,   8'h02,   8'h02,   8'h80};
        idle_on = 1'b1;
        for (int i = 0; i < 8; i++) begin
            place_instruction(ops[i], args[i]);
            issue_exec();
        end
        // jump landed on 255: operand comes from address 0, next pc wraps to 1
        issue_item(FUNC_LOAD, shadow_pc, OP_ADD);
        issue_exec();
    endtask

    // mostly well-formed instructions written at pc and run, some reruns of what is
    // already there, plus stray loads anywhere in the store
    task automatic test_random_programs(input int item_goal, input bit allow_idle);
        int         start;
        int         pick;
        logic [7:0] op;
        logic [7:0] arg;
        start = items_sent;
        idle_on = allow_idle;
        while (items_sent - start < item_goal) begin
            if ($urandom_range(0, 39) == 0) idle_on = allow_idle && $urandom_range(0, 3) != 0;
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                issue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                // never run a fault here: halting is reserved for the last test
                if (pick >= 40 || !instruction_runs(shadow_pc)) begin
                    op = pick_opcode();
                    arg = (op == OP_IMM) ? 8'($urandom_range(0, 255))
                                         : 8'd1 << $urandom_range(0, 7);
                    place_instruction(op, arg);
                end
                issue_exec();
            end
        end
    endtask

    // one fault per reset: either a bad register select (opcode known or not) or an
    // unknown opcode, then executes and loads while halted
    task automatic test_sticky_halt();
        logic [7:0] op;
        logic [7:0] arg;
        idle_on = 1'b0;
        if ($urandom_range(0, 1) == 1) begin
            op = ($urandom_range(0, 1) == 1) ? pick_opcode() : non_onehot_byte();
            if (op == OP_IMM) op = OP_ADD;
            arg = non_onehot_byte();
        end else begin
            op = non_onehot_byte();
            arg = 8'd1 << $urandom_range(0, 7);
        end
        place_instruction(op, arg);
        issue_exec();
        repeat (3) issue_exec();
        issue_item(FUNC_LOAD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        // a valid instruction at pc still must not run
        place_instruction(OP_IMM, 8'($urandom_range(0, 255)));
        issue_exec();
    endtask

    // result side back-pressure in random bursts
    initial begin : sink_ready
        int stall_len;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_len = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (stall_len) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare every accepted result transaction with the oldest expected view
    always @(posedge aclk) begin : result_check
        cpu_view_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_views.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result pc %02h acc %02h status %0d",
                             m_tdata[7:0], m_tdata[15:8], m_tdata[17:16]);
            end else begin
                want = expected_views.pop_front();
                if (m_tdata[7:0] !== want.pc || m_tdata[15:8] !== want.acc ||
                    m_tdata[17:16] !== want.status || m_tdata[23:18] !== 6'd0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"result %0d: expected pc %02h acc %02h status %0d, ",
                                  "got pc %02h acc %02h status %0d pad %02h"},
                                 results_checked, want.pc, want.acc, want.status,
                                 m_tdata[7:0], m_tdata[15:8], m_tdata[17:16], m_tdata[23:18]);
                end
            end
        end
    end

    initial begin
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = FUNC_LOAD;
        aresetn = 1'b0;
        idle_on = 1'b1;
        shadow_pc = '0;
        shadow_acc = '0;
        shadow_halt = HALT_RUN;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        foreach (shadow_ram[i]) shadow_ram[i] = '0;
        foreach (shadow_prog[i]) shadow_prog[i] = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_program();
        test_random_programs(680, 1'b1);
        test_random_programs(100, 1'b0);
        test_sticky_halt();

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_views.size() != 0) @(posedge aclk);
        // leave room for any stray result
        repeat (8) @(posedge aclk);

        $display("sent %0d transactions (%0d instructions run, %0d jumps taken)",
                 items_sent, exec_count, jumps_taken);
        $display("checked %0d results, %0d mismatches, run ended in state %s",
                 results_checked, mismatch_count, shadow_halt.name());
        if (mismatch_count == 0 && expected_views.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
